>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. All sample on i_clk and are off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Consequent that must hold on the same edge as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/htd_pkg.sv
// ----------------------------------------------------------------------------
// htd_pkg
// Types and constants shared by the Huffman tree decoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package htd_pkg;

    localparam int MAX_SYMBOLS_DEF = 256;
    localparam int WEIGHT_W        = 31;
    localparam int SYM_W           = 8;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = 31'h7FFF_FFFF;
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_BUILD  = 2'd1,
        OP_DECODE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [SYM_W-1:0]    entry_symbol;
        logic [WEIGHT_W-1:0] entry_count;
        logic [7:0]          code_byte;
        logic [3:0]          valid_bits;
    } t_in_beat;

    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last_of_run;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LONE_A,
        ST_LONE_B,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_SCAN,
        ST_MERGE,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_LEAF,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic take;
        logic lone_a;
        logic lone_b;
        logic init_rd;
        logic init_wr;
        logic scan;
        logic merge;
        logic walk_rd;
        logic walk_ev;
        logic leaf;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    tree_ready;
        logic    total_zero;
        logic    total_one;
        logic    nbits_zero;
        logic    init_last;
        logic    scan_done;
        logic    round_last;
        logic    child_leaf;
        logic    bits_last;
        logic    has_syms;
        logic    emit_last;
        logic    out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

>>> rtl/core/htd_ctrl.sv
// ----------------------------------------------------------------------------
// htd_ctrl
// Sequencer for table load, tree build, tree walk and symbol output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htd_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_in_valid,
    output logic            o_in_ready,
    input  htd_pkg::t_dp_sts i_sts,
    output htd_pkg::t_dp_cmd o_cmd
);

    htd_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= htd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            htd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_sts.op)
                        htd_pkg::OP_BUILD: begin
                            if (i_sts.total_one) begin
                                n_state = htd_pkg::ST_LONE_A;
                            end else if (!i_sts.total_zero) begin
                                n_state = htd_pkg::ST_INIT_RD;
                            end
                        end
                        htd_pkg::OP_DECODE: begin
                            if (i_sts.tree_ready && !i_sts.nbits_zero) begin
                                n_state = htd_pkg::ST_WALK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            htd_pkg::ST_LONE_A: begin
                o_cmd.lone_a = 1'b1;
                n_state      = htd_pkg::ST_LONE_B;
            end
            htd_pkg::ST_LONE_B: begin
                o_cmd.lone_b = 1'b1;
                n_state      = htd_pkg::ST_IDLE;
            end
            htd_pkg::ST_INIT_RD: begin
                o_cmd.init_rd = 1'b1;
                n_state       = htd_pkg::ST_INIT_WR;
            end
            htd_pkg::ST_INIT_WR: begin
                o_cmd.init_wr = 1'b1;
                n_state = i_sts.init_last ? htd_pkg::ST_SCAN : htd_pkg::ST_INIT_RD;
            end
            htd_pkg::ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = htd_pkg::ST_MERGE;
                end
            end
            htd_pkg::ST_MERGE: begin
                o_cmd.merge = 1'b1;
                n_state = i_sts.round_last ? htd_pkg::ST_IDLE : htd_pkg::ST_SCAN;
            end
            htd_pkg::ST_WALK_RD: begin
                o_cmd.walk_rd = 1'b1;
                n_state       = htd_pkg::ST_WALK_EV;
            end
            htd_pkg::ST_WALK_EV: begin
                o_cmd.walk_ev = 1'b1;
                if (i_sts.child_leaf) begin
                    n_state = htd_pkg::ST_LEAF;
                end else if (i_sts.bits_last) begin
                    n_state = i_sts.has_syms ? htd_pkg::ST_EMIT : htd_pkg::ST_IDLE;
                end
            end
            htd_pkg::ST_LEAF: begin
                o_cmd.leaf = 1'b1;
                n_state = i_sts.bits_last ? htd_pkg::ST_EMIT : htd_pkg::ST_WALK_RD;
            end
            htd_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = htd_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = htd_pkg::ST_IDLE;
        endcase
    end

    `ASSERT_IMPLY(a_emit_has_syms, r_state == htd_pkg::ST_EMIT, i_sts.has_syms,
        "emit state with empty symbol buffer")
    `ASSERT_IMPLY(a_merge_needs_pair, r_state == htd_pkg::ST_MERGE,
        !i_sts.total_zero && !i_sts.total_one, "merge with fewer than two entries")

endmodule

`default_nettype wire

>>> rtl/core/htd_datapath.sv
// ----------------------------------------------------------------------------
// htd_datapath
// Node and slot memories, minimum scan, merge, tree walk and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module htd_datapath #(
    parameter int MAX_SYMBOLS = htd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  htd_pkg::t_in_beat i_in_data,
    input  htd_pkg::t_dp_cmd  i_cmd,
    output htd_pkg::t_dp_sts  o_sts,
    input  wire               i_out_ready,
    output logic              o_out_valid,
    output htd_pkg::t_out_beat o_out_data
);

    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = $clog2(NODES);
    localparam int SW    = $clog2(MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int WW    = htd_pkg::WEIGHT_W;
    localparam int YW    = htd_pkg::SYM_W;
    localparam int RECW  = WW + YW + 2 * NW;
    localparam int SLW   = WW + NW;

    // node record: weight | symbol | left | right
    logic [RECW-1:0] node_mem [NODES];
    logic [RECW-1:0] r_nrd;
    logic [SLW-1:0]  slot_mem [MAX_SYMBOLS];
    logic [SLW-1:0]  r_srd;
    // used flag per slot; a build rewrites the first n before any scan reads them
    logic            used_mem [MAX_SYMBOLS];
    logic            r_urd;

    logic [NW-1:0]   nd_raddr, nd_waddr;
    logic [RECW-1:0] nd_wdata;
    logic            nd_we;
    logic [SW-1:0]   sl_waddr;
    logic [SLW-1:0]  sl_wdata;
    logic            sl_we;
    logic [SW-1:0]   us_waddr;
    logic            us_wdata;
    logic            us_we;

    logic [CW-1:0]   r_total, r_j;
    logic            r_ready;
    logic [NW-1:0]   r_walk, r_root;
    logic [SW-1:0]   r_k, r_pj, r_a, r_b;
    logic            r_pv, r_fa, r_fb;
    logic [WW-1:0]   r_wa, r_wb;
    logic [NW-1:0]   r_na, r_nb;
    logic [7:0]      r_byte;
    logic [3:0]      r_left, r_cnt, r_oi;
    logic [YW-1:0]   r_buf [8];
    logic            r_ov, r_olast;
    logic [YW-1:0]   r_osym;

    logic [WW-1:0]   rd_w_unused_chk;
    logic [YW-1:0]   rd_sym;
    logic [NW-1:0]   rd_left, rd_right, child, m_node;
    logic [WW-1:0]   sl_w;
    logic [NW-1:0]   sl_node;
    logic [WW:0]     sum_raw;
    logic [WW-1:0]   sum_sat;
    logic [SW-1:0]   lo, hi;
    logic            add_we;

    assign rd_w_unused_chk = r_nrd[RECW-1 -: WW];
    assign rd_sym   = r_nrd[2*NW +: YW];
    assign rd_left  = r_nrd[NW +: NW];
    assign rd_right = r_nrd[0 +: NW];
    assign child    = r_byte[7] ? rd_right : rd_left;
    assign sl_w     = r_srd[NW +: WW];
    assign sl_node  = r_srd[0 +: NW];
    assign m_node   = NW'(MAX_SYMBOLS) + NW'(r_k);
    assign sum_raw  = {1'b0, r_wa} + {1'b0, r_wb};
    assign sum_sat  = sum_raw[WW] ? htd_pkg::WEIGHT_MAX : sum_raw[WW-1:0];
    assign lo       = (r_a < r_b) ? r_a : r_b;
    assign hi       = (r_a < r_b) ? r_b : r_a;
    assign add_we   = i_cmd.take && (i_in_data.opcode == htd_pkg::OP_ADD)
                      && (r_total < CW'(MAX_SYMBOLS));

    // node, slot and used-flag memory port selection
    always_comb begin
        nd_we    = 1'b0;
        nd_waddr = '0;
        nd_wdata = '0;
        if (add_we) begin
            nd_we    = 1'b1;
            nd_waddr = NW'(r_total);
            nd_wdata = {i_in_data.entry_count, i_in_data.entry_symbol, {(2*NW){1'b0}}};
        end else if (i_cmd.lone_a) begin
            nd_we    = 1'b1;
            nd_waddr = NW'(1);
        end else if (i_cmd.lone_b) begin
            nd_we    = 1'b1;
            nd_waddr = NW'(MAX_SYMBOLS);
            nd_wdata = {{(WW+YW){1'b0}}, NW'(0), NW'(1)};
        end else if (i_cmd.merge) begin
            nd_we    = 1'b1;
            nd_waddr = m_node;
            nd_wdata = {sum_sat, {YW{1'b0}}, r_na, r_nb};
        end
        if (i_cmd.init_rd) begin
            nd_raddr = NW'(r_j);
        end else if (i_cmd.walk_rd) begin
            nd_raddr = r_walk;
        end else begin
            nd_raddr = child;
        end
        sl_we    = i_cmd.init_wr || i_cmd.merge;
        sl_waddr = i_cmd.merge ? lo : r_j[SW-1:0];
        sl_wdata = i_cmd.merge ? {sum_sat, m_node} : {rd_w_unused_chk, NW'(r_j)};
        // init frees each slot, merge retires the higher slot of the pair
        us_we    = i_cmd.init_wr || i_cmd.merge;
        us_waddr = i_cmd.merge ? hi : r_j[SW-1:0];
        us_wdata = i_cmd.merge;
    end

    always_ff @(posedge i_clk) begin
        if (nd_we) begin
            node_mem[nd_waddr] <= nd_wdata;
        end
        r_nrd <= node_mem[nd_raddr];
        if (sl_we) begin
            slot_mem[sl_waddr] <= sl_wdata;
        end
        r_srd <= slot_mem[r_j[SW-1:0]];
        if (us_we) begin
            used_mem[us_waddr] <= us_wdata;
        end
        r_urd <= used_mem[r_j[SW-1:0]];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ready <= 1'b0;
            r_walk  <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
            r_fa    <= 1'b0;
            r_fb    <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
            r_left  <= '0;
            r_oi    <= '0;
        end else begin
            if (i_cmd.take) begin
                case (i_in_data.opcode)
                    htd_pkg::OP_ADD: begin
                        if (add_we) begin
                            r_total <= r_total + CW'(1);
                        end
                        r_ready <= 1'b0;
                        r_walk  <= '0;
                    end
                    htd_pkg::OP_BUILD: begin
                        r_ready <= 1'b0;
                        r_walk  <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                    end
                    htd_pkg::OP_DECODE: begin
                        r_left <= (i_in_data.valid_bits > htd_pkg::BITS_PER_BYTE)
                                  ? htd_pkg::BITS_PER_BYTE : i_in_data.valid_bits;
                        r_cnt  <= '0;
                        r_oi   <= '0;
                    end
                    htd_pkg::OP_CLEAR: begin
                        r_total <= '0;
                        r_ready <= 1'b0;
                        r_walk  <= '0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.lone_b) begin
                r_walk  <= NW'(MAX_SYMBOLS);
                r_ready <= 1'b1;
            end
            if (i_cmd.init_wr) begin
                r_j <= o_sts.init_last ? '0 : r_j + CW'(1);
                if (o_sts.init_last) begin
                    r_pv <= 1'b0;
                    r_fa <= 1'b0;
                    r_fb <= 1'b0;
                end
            end
            if (i_cmd.scan) begin
                if (r_j < r_total) begin
                    r_j  <= r_j + CW'(1);
                    r_pv <= 1'b1;
                end else begin
                    r_pv <= 1'b0;
                end
                if (r_pv && !r_urd) begin
                    if (!r_fa || sl_w < r_wa) begin
                        r_fa <= 1'b1;
                        r_fb <= r_fa;
                    end else if (!r_fb || sl_w < r_wb) begin
                        r_fb <= 1'b1;
                    end
                end
            end
            if (i_cmd.merge) begin
                r_k <= r_k + SW'(1);
                if (o_sts.round_last) begin
                    r_ready <= 1'b1;
                    r_walk  <= m_node;
                end else begin
                    r_j  <= '0;
                    r_pv <= 1'b0;
                    r_fa <= 1'b0;
                    r_fb <= 1'b0;
                end
            end
            if (i_cmd.walk_ev && !o_sts.child_leaf) begin
                r_walk <= child;
                r_left <= r_left - 4'd1;
            end
            if (i_cmd.leaf) begin
                r_walk <= r_root;
                r_left <= r_left - 4'd1;
                r_cnt  <= r_cnt + 4'd1;
            end
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
                r_oi <= r_oi + 4'd1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_byte <= i_in_data.code_byte;
        end
        if (i_cmd.scan) begin
            r_pj <= r_j[SW-1:0];
            if (r_pv && !r_urd) begin
                if (!r_fa || sl_w < r_wa) begin
                    r_a  <= r_pj;
                    r_wa <= sl_w;
                    r_na <= sl_node;
                    r_b  <= r_a;
                    r_wb <= r_wa;
                    r_nb <= r_na;
                end else if (!r_fb || sl_w < r_wb) begin
                    r_b  <= r_pj;
                    r_wb <= sl_w;
                    r_nb <= sl_node;
                end
            end
        end
        if (i_cmd.merge) begin
            r_root <= m_node;
        end
        if (i_cmd.lone_b) begin
            r_root <= NW'(MAX_SYMBOLS);
        end
        if ((i_cmd.walk_ev && !o_sts.child_leaf) || i_cmd.leaf) begin
            r_byte <= {r_byte[6:0], 1'b0};
        end
        if (i_cmd.leaf) begin
            r_buf[r_cnt[2:0]] <= rd_sym;
        end
        if (i_cmd.emit) begin
            r_osym  <= r_buf[r_oi[2:0]];
            r_olast <= o_sts.emit_last;
        end
    end

    always_comb begin
        o_sts.op         = i_in_data.opcode;
        o_sts.tree_ready = r_ready;
        o_sts.total_zero = (r_total == '0);
        o_sts.total_one  = (r_total == CW'(1));
        o_sts.nbits_zero = (i_in_data.valid_bits == 4'd0);
        o_sts.init_last  = (r_j + CW'(1) == r_total);
        o_sts.scan_done  = (r_j == r_total) && !r_pv;
        o_sts.round_last = (CW'(r_k) + CW'(2) == r_total);
        o_sts.child_leaf = (child < NW'(MAX_SYMBOLS));
        o_sts.bits_last  = (r_left == 4'd1);
        o_sts.has_syms   = (r_cnt != 4'd0);
        o_sts.emit_last  = (r_oi + 4'd1 == r_cnt);
        o_sts.out_free   = !r_ov || i_out_ready;
    end

    assign o_out_valid            = r_ov;
    assign o_out_data.symbol      = r_osym;
    assign o_out_data.last_of_run = r_olast;

    `ASSERT_ALWAYS(a_buf_bound, r_cnt <= htd_pkg::BITS_PER_BYTE, "symbol buffer overrun")
    `ASSERT_IMPLY(a_walk_internal, r_ready, r_walk >= NW'(MAX_SYMBOLS),
        "walk position is not an internal node")
    `ASSERT_IMPLY(a_merge_pair, i_cmd.merge, r_fa && r_fb && (r_a != r_b),
        "merge without two distinct minima")

endmodule

`default_nettype wire

>>> rtl/core/huffman_tree_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_decoder
// Loads a symbol/count table, builds a Huffman tree and decodes bytes with it.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | beat
//  in      | input     | i_in_valid / o_in_ready   | t_in_beat  (op + fields)
//  out     | output    | o_out_valid / i_out_ready | t_out_beat (symbol, last)
//
//  Add, clear, empty build and a decode with no tree or no bits end in idle.
//  A build of n >= 2 entries runs a copy pass, then, per merge round, a scan
//  over the first n slots, one slot read a cycle, and a merge.
//  A lone-entry build writes a dummy leaf, then the root (LONE_A, LONE_B).
//  A decode reads the current node, then walks the bits; a bit that ends at
//  a leaf adds a leaf step and, unless it is the final bit, a new read of
//  the root (single read port on the node memory); symbols go out last.
//  Reset is synchronous, active low; node, slot and used-flag memories need
//  no clearing.
//  A stalled output holds the current beat; the block takes the next input
//  beat as soon as the last symbol sits in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_tree_decoder #(
    parameter int MAX_SYMBOLS = htd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  htd_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output htd_pkg::t_out_beat o_out_data
);

    // command and status between sequencer and datapath
    htd_pkg::t_dp_cmd cmd;
    htd_pkg::t_dp_sts sts;

    htd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    htd_datapath #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for huffman_tree_decoder. A directed table, then random
// table/build/decode phases. A behavioural tree builder and walker predicts
// every output beat. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
    import htd_pkg::*;

    localparam int NSYM       = 256;
    localparam int NNODE      = 2 * NSYM - 1;
    localparam int CYCLE_CAP  = 1_500_000;
    localparam int TAIL_WAIT  = 60;
    localparam int ITEM_GOAL  = 450;

    // ------------------------------------------------------------------
    // clock, reset, DUT
    // ------------------------------------------------------------------
    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_beat  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    huffman_tree_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // ------------------------------------------------------------------
    // shadow of the decoder state
    // ------------------------------------------------------------------
    int unsigned   tbl_total;
    bit [30:0]     sh_weight [NNODE];
    bit [7:0]      sh_symbol [NNODE];
    bit [8:0]      sh_left   [NNODE];
    bit [8:0]      sh_right  [NNODE];
    bit [8:0]      sh_slot   [NSYM];
    bit            sh_taken  [NSYM];
    int unsigned   walk_pos;
    bit            have_tree;

    t_out_beat     sym_expected_q [$];
    int            errors = 0;
    int            cycles = 0;
    bit            calm = 1'b0;    // no idling on either side while set

    function automatic int unsigned clamp_node(int unsigned n);
        return (n < NNODE) ? n : 0;
    endfunction

    // lowest-weight free slot among the first n, lowest index wins ties
    function automatic int unsigned lightest_slot(int unsigned n);
        int unsigned best;
        bit [30:0]   bw;
        bit          found;
        best = 0;
        bw = '0;
        found = 1'b0;
        for (int unsigned j = 0; j < n; j++) begin
            if (!sh_taken[j]) begin
                if (!found || sh_weight[clamp_node(sh_slot[j])] < bw) begin
                    found = 1'b1;
                    bw = sh_weight[clamp_node(sh_slot[j])];
                    best = j;
                end
            end
        end
        return best;
    endfunction

    task automatic grow_tree();
        int unsigned n, a, b, na, nb, m, lo;
        bit [31:0]   sum;
        n = (tbl_total > NSYM) ? NSYM : tbl_total;
        have_tree = 1'b0;
        walk_pos = 0;
        if (n == 0) return;
        for (int unsigned j = 0; j < n; j++) begin
            sh_slot[j] = j[8:0];
            sh_taken[j] = 1'b0;
        end
        if (n == 1) begin
            // lone symbol: dummy right leaf, symbol 0
            sh_weight[1] = '0;
            sh_symbol[1] = '0;
            sh_left[NSYM] = 9'd0;
            sh_right[NSYM] = 9'd1;
            sh_weight[NSYM] = sh_weight[0];
            sh_symbol[NSYM] = '0;
            sh_slot[0] = 9'(NSYM);
        end else begin
            for (int unsigned k = 0; k + 1 < n; k++) begin
                m = NSYM + k;
                a = lightest_slot(n);
                sh_taken[a] = 1'b1;
                b = lightest_slot(n);
                sh_taken[b] = 1'b1;
                na = clamp_node(sh_slot[a]);
                nb = clamp_node(sh_slot[b]);
                sum = {1'b0, sh_weight[na]} + {1'b0, sh_weight[nb]};
                if (sum > 32'h7FFF_FFFF) sum = 32'h7FFF_FFFF;
                sh_left[m] = na[8:0];
                sh_right[m] = nb[8:0];
                sh_weight[m] = sum[30:0];
                sh_symbol[m] = '0;
                lo = (a < b) ? a : b;
                sh_slot[lo] = m[8:0];
                sh_taken[lo] = 1'b0;
            end
        end
        walk_pos = clamp_node(sh_slot[0]);
        have_tree = 1'b1;
    endtask

    // advance the shadow by one input beat, return the symbols it yields
    task automatic huff_predict(input t_in_beat b, output t_out_beat res[$]);
        int unsigned nbits, root, cur;
        bit          bitv;
        t_out_beat   o;
        res = {};
        case (b.opcode)
            OP_ADD: begin
                if (tbl_total < NSYM) begin
                    sh_symbol[tbl_total] = b.entry_symbol;
                    sh_weight[tbl_total] = b.entry_count;
                    tbl_total++;
                end
                have_tree = 1'b0;
                walk_pos = 0;
            end
            OP_BUILD: grow_tree();
            OP_DECODE: begin
                if (have_tree) begin
                    nbits = (b.valid_bits > 8) ? 8 : b.valid_bits;
                    root = clamp_node(sh_slot[0]);
                    cur = clamp_node(walk_pos);
                    for (int unsigned i = 0; i < nbits; i++) begin
                        bitv = b.code_byte[7 - i];
                        cur = clamp_node(bitv ? sh_right[cur] : sh_left[cur]);
                        if (cur < NSYM) begin
                            o.symbol = sh_symbol[cur];
                            o.last_of_run = 1'b0;
                            res.insert(res.size(), o);
                            cur = root;
                        end
                    end
                    walk_pos = cur;
                    if (res.size() > 0) res[res.size() - 1].last_of_run = 1'b1;
                end
            end
            default: begin
                tbl_total = 0;
                have_tree = 1'b0;
                walk_pos = 0;
                for (int j = 0; j < NSYM; j++) sh_taken[j] = 1'b0;
            end
        endcase
    endtask

    task automatic report(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------
    task automatic send_beat(input t_in_beat b, output t_out_beat res[$]);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= b;
        do @(posedge i_clk); while (!in_ready);
        huff_predict(b, res);
    endtask

    // send and queue the predicted symbols
    task automatic push_beat(input t_in_beat b);
        t_out_beat res [$];
        send_beat(b, res);
        foreach (res[i]) sym_expected_q.insert(sym_expected_q.size(), res[i]);
    endtask

    function automatic t_in_beat mk(t_opcode op, bit [7:0] sym, bit [30:0] cnt,
                                    bit [7:0] cb, bit [3:0] vb);
        t_in_beat b;
        b.opcode = op;
        b.entry_symbol = sym;
        b.entry_count = cnt;
        b.code_byte = cb;
        b.valid_bits = vb;
        return b;
    endfunction

    function automatic t_in_beat rnd_beat(t_opcode op);
        return mk(op, 8'($urandom), 31'($urandom), 8'($urandom), 4'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // directed table; typed rows carry n copies of one symbol
    // ------------------------------------------------------------------
    typedef struct {
        t_in_beat  beat;
        bit        typed;
        int        n_exp;
        bit [7:0]  exp_sym;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(t_in_beat b, bit typed = 1'b0, int n = 0,
                           bit [7:0] s = 8'h00);
        t_dir_row r;
        r.beat = b;
        r.typed = typed;
        r.n_exp = n;
        r.exp_sym = s;
        dir_rows.insert(dir_rows.size(), r);
    endtask

    task automatic fill_table();
        add_row(mk(OP_DECODE, 8'h00, '0, 8'hFF, 4'd8), 1, 0);       // no tree yet
        add_row(mk(OP_BUILD, 8'hFF, 31'h7FFF_FFFF, 8'h00, 4'd15), 1, 0); // empty build
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h00, 4'd8), 1, 0);
        add_row(mk(OP_ADD, 8'h41, 31'd5, 8'h00, 4'd0));
        add_row(mk(OP_BUILD, 8'h00, '0, 8'h00, 4'd0));             // lone symbol
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h00, 4'd8), 1, 8, 8'h41);
        add_row(mk(OP_DECODE, 8'h00, '0, 8'hFF, 4'd15), 1, 8, 8'h00); // dummy leaf
        add_row(mk(OP_DECODE, 8'h00, '0, 8'hA5, 4'd0), 1, 0);
        add_row(mk(OP_ADD, 8'hFF, 31'h7FFF_FFFF, 8'h00, 4'd0));    // drops tree
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h00, 4'd8), 1, 0);
        add_row(mk(OP_ADD, 8'h00, 31'h7FFF_FFFF, 8'hFF, 4'd15));   // saturation
        add_row(mk(OP_ADD, 8'h80, 31'd0, 8'h00, 4'd0));
        add_row(mk(OP_BUILD, 8'h00, '0, 8'h00, 4'd0));
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h5A, 4'd8));
        add_row(mk(OP_DECODE, 8'h00, '0, 8'hC3, 4'd3));            // walk carries over
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h3C, 4'd7));
        add_row(mk(OP_BUILD, 8'h00, '0, 8'h00, 4'd0));             // rebuild
        add_row(mk(OP_DECODE, 8'h00, '0, 8'hFF, 4'd8));
        add_row(mk(OP_CLEAR, 8'h00, '0, 8'h00, 4'd0));
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h00, 4'd8), 1, 0);
        add_row(mk(OP_ADD, 8'h01, 31'd1, 8'h00, 4'd0));            // equal weights
        add_row(mk(OP_ADD, 8'h02, 31'd1, 8'h00, 4'd0));
        add_row(mk(OP_ADD, 8'h03, 31'd1, 8'h00, 4'd0));
        add_row(mk(OP_BUILD, 8'h00, '0, 8'h00, 4'd0));
        add_row(mk(OP_DECODE, 8'h00, '0, 8'h96, 4'd8));
    endtask

    function automatic bit [30:0] rnd_count();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 31'($urandom_range(0, 15));
        if (r < 9) return 31'($urandom);
        return 31'h7FFF_FFFF;
    endfunction

    function automatic t_in_beat rnd_decode();
        t_in_beat b;
        b = rnd_beat(OP_DECODE);
        if ($urandom_range(0, 4) != 0) b.valid_bits = 4'd8;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_out_beat res [$];
        t_out_beat o;
        int        items;
        int        n;
        bit        big_done;

        tbl_total = 0;
        walk_pos = 0;
        have_tree = 1'b0;
        for (int j = 0; j < NSYM; j++) sh_taken[j] = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fill_table();
        foreach (dir_rows[r]) begin
            send_beat(dir_rows[r].beat, res);
            if (dir_rows[r].typed) begin
                for (int i = 0; i < dir_rows[r].n_exp; i++) begin
                    o.symbol = dir_rows[r].exp_sym;
                    o.last_of_run = (i == dir_rows[r].n_exp - 1);
                    sym_expected_q.insert(sym_expected_q.size(), o);
                end
            end else begin
                foreach (res[i]) sym_expected_q.insert(sym_expected_q.size(), res[i]);
            end
        end

        // random phases: an optional clear, load a table, build, decode a stream
        items = dir_rows.size();
        big_done = 1'b0;
        while (items < ITEM_GOAL) begin
            calm = ($urandom_range(0, 5) == 0);
            if (!big_done && items > ITEM_GOAL / 8) begin
                // hold off until the output side has drained, then a full table
                in_valid <= 1'b0;
                do @(posedge i_clk); while (sym_expected_q.size() != 0);
                push_beat(rnd_beat(OP_CLEAR));
                for (int j = 0; j < NSYM + 1; j++) begin
                    t_in_beat b;
                    b = rnd_beat(OP_ADD);
                    b.entry_count = rnd_count();
                    push_beat(b);       // the last one is beyond the table
                end
                push_beat(rnd_beat(OP_BUILD));
                for (int j = 0; j < 20; j++) push_beat(rnd_decode());
                items += NSYM + 23;
                big_done = 1'b1;
            end
            if ($urandom_range(0, 3) != 0) begin
                push_beat(rnd_beat(OP_CLEAR));
                items++;
            end
            n = $urandom_range(0, 9);
            if (n == 0) n = $urandom_range(0, 1);
            else n = $urandom_range(2, 16);
            for (int j = 0; j < n; j++) begin
                t_in_beat b;
                b = rnd_beat(OP_ADD);
                b.entry_count = rnd_count();
                push_beat(b);
                items++;
            end
            push_beat(rnd_beat(OP_BUILD));
            items++;
            repeat ($urandom_range(5, 20)) begin
                int r;
                r = $urandom_range(0, 99);
                if (r < 93) push_beat(rnd_decode());
                else push_beat(rnd_beat(t_opcode'($urandom_range(0, 3))));   // noise
                items++;
            end
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (sym_expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (errors == 0 && sym_expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: random stalls, checks each accepted beat in order
    // ------------------------------------------------------------------
    initial begin
        t_out_beat want;
        int        stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_valid && out_ready) begin
                if (sym_expected_q.size() == 0) begin
                    report($sformatf("unexpected beat sym=%02h", out_data.symbol));
                end else begin
                    want = sym_expected_q.pop_front();
                    if (out_data.symbol !== want.symbol)
                        report($sformatf("symbol %02h, want %02h",
                                         out_data.symbol, want.symbol));
                    if (out_data.last_of_run !== want.last_of_run)
                        report($sformatf("last_of_run %b, want %b (sym %02h)",
                                         out_data.last_of_run, want.last_of_run,
                                         want.symbol));
                end
            end
            if (stall > 0) begin
                stall--;
                out_ready <= 1'b0;
            end else begin
                stall = idle_len();
                out_ready <= (stall == 0);
            end
        end
    end

    // watchdog
    initial begin
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim.f
+incdir+rtl/core
rtl/core/htd_pkg.sv
rtl/core/htd_ctrl.sv
rtl/core/htd_datapath.sv
rtl/core/huffman_tree_decoder.sv
tb/testbench.sv
